// File: rtl/device_class_table_search_top_macros.svh
// assertion macros shared by the device class table search checkers
// depends on clk and rst_n being visible where a macro is used
`ifndef DEVICE_CLASS_TABLE_SEARCH_TOP_MACROS_SVH
`define DEVICE_CLASS_TABLE_SEARCH_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define DCTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcts assertion failed");

// next-cycle implication, disabled in reset
`define DCTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcts assertion failed");

`endif

// File: rtl/dcts_pkg.sv
// types and constants of the device class table search block
// no dependencies
package dcts_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] bus_num;
        logic [4:0] dev_num;
        logic [2:0] func_num;
        logic [15:0] vendor_id;
        logic [7:0] class_code;
        logic [7:0] sub_class;
        logic [7:0] interface_code;
        logic [6:0] max_matches;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] hit_bus;
        logic [7:0] hit_dev;
        logic [7:0] hit_func;
        logic [6:0] match_index;
        logic       last;
    } result_t;

    // one stored function: location plus class triple
    typedef struct packed {
        logic [7:0] ifc;
        logic [7:0] sub;
        logic [7:0] cls;
        logic [2:0] func;
        logic [4:0] dev;
        logic [7:0] bus;
    } entry_t;

    typedef struct packed {
        logic [7:0] cls;
        logic [7:0] sub;
        logic [7:0] ifc;
    } key_t;

    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_ABSENT   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_MATCH    = 3'd3,
        STAT_NO_MATCH = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } fsm_state_t;

    localparam logic        CMD_INSERT      = 1'b0;
    localparam logic [15:0] ABSENT_VENDOR   = 16'hFFFF;
    localparam logic [7:0]  ANY_CODE        = 8'hFF;
    localparam logic [7:0]  NO_HIT          = 8'hFF;
    localparam logic [6:0]  FILL_REPORT_CAP = 7'd64;

endpackage

// File: rtl/dcts_table.sv
// entry memory of the device class table search, with registered read
// and the class match compare on the read data; depends on dcts_pkg
module dcts_table #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  dcts_pkg::entry_t wr_entry,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  dcts_pkg::key_t  key,
    output dcts_pkg::entry_t rd_entry,
    output logic            hit
);
    import dcts_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

    // class exact, subclass and interface with wildcard
    assign hit = (rd_entry_reg.cls == key.cls)
              && ((key.sub == ANY_CODE) || (rd_entry_reg.sub == key.sub))
              && ((key.ifc == ANY_CODE) || (rd_entry_reg.ifc == key.ifc));

endmodule

// File: rtl/device_class_table_search_top.sv
// top level of the device class table search: command sequencer,
// fill counter and result register; depends on dcts_pkg and dcts_table
//
// channel   direction  handshake                     payload
// command   in         start high while busy low     item   (dcts_pkg::item_t)
// result    out        result_strobe, one cycle      result (dcts_pkg::result_t)
//
// an insert never raises busy, and its result is shown in the cycle after it is accepted
// a query scans the stored entries in order through one memory read port,
// one entry per cycle, and holds busy until every entry below the fill count
// is read or max_matches locations are found
// rst_n clears fill count, sequencer and result strobe; the entry memory is
// not cleared, a query only reads entries below the fill count
// the receiver cannot stall: each result transaction is shown for one cycle
module device_class_table_search_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_REPORT  = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dcts_pkg::item_t item,
    output logic            result_strobe,
    output dcts_pkg::result_t result
);
    import dcts_pkg::*;

    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (FW > 7) ? FW : 7;

    // control state
    fsm_state_t    state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] scan_idx_reg, scan_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [6:0]    found_reg, found_next;
    logic          pend_vld_reg, pend_vld_next;
    logic          res_vld_reg, res_vld_next;

    // payload state
    key_t          key_reg, key_next;
    logic [6:0]    limit_reg, limit_next;
    entry_t        pend_reg, pend_next;
    logic [6:0]    pend_ord_reg, pend_ord_next;
    result_t       res_reg, res_next;

    // memory side
    logic          wr_en;
    entry_t        wr_entry;
    logic          rd_en;
    entry_t        rd_entry;
    logic          hit;

    // helpers
    logic          accept;
    logic          issue;
    logic          take;
    logic [FW-1:0] fill_after;
    logic [XW-1:0] fill_ext;
    logic [6:0]    limit_in;

    dcts_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (fill_reg[AW-1:0]),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (scan_idx_reg[AW-1:0]),
        .key      (key_reg),
        .rd_entry (rd_entry),
        .hit      (hit)
    );

    assign accept = start && (state_reg == S_IDLE);

    assign wr_entry = '{ifc: item.interface_code, sub: item.sub_class,
                        cls: item.class_code, func: item.func_num,
                        dev: item.dev_num, bus: item.bus_num};

    // zero means one, anything above the report cap is clipped
    always_comb
    begin
        if (item.max_matches == 7'd0)
        begin
            limit_in = 7'd1;
        end
        else if (item.max_matches > 7'(MAX_REPORT))
        begin
            limit_in = 7'(MAX_REPORT);
        end
        else
        begin
            limit_in = item.max_matches;
        end
    end

    // scan pipeline: issue a read at scan_idx, compare in the next cycle
    assign issue = (state_reg == S_SCAN) && (scan_idx_reg < fill_reg)
                && (found_reg < limit_reg);
    assign rd_en = issue;
    // reads issued after the limit was reached are dropped here
    assign take  = (state_reg == S_SCAN) && rd_vld_reg && hit && (found_reg < limit_reg);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = 1'b0;
        found_next    = found_reg;
        pend_vld_next = pend_vld_reg;
        res_vld_next  = 1'b0;
        key_next      = key_reg;
        limit_next    = limit_reg;
        pend_next     = pend_reg;
        pend_ord_next = pend_ord_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        fill_after    = fill_reg;
        fill_ext      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_INSERT)
                    begin
                        res_next.status = STAT_INSERTED;
                        if (fill_reg >= FW'(TABLE_DEPTH))
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else if (item.vendor_id == ABSENT_VENDOR)
                        begin
                            res_next.status = STAT_ABSENT;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            fill_after = fill_reg + FW'(1);
                        end
                        fill_next = fill_after;
                        fill_ext  = XW'(fill_after);
                        res_next.hit_bus     = NO_HIT;
                        res_next.hit_dev     = NO_HIT;
                        res_next.hit_func    = NO_HIT;
                        res_next.match_index = (fill_ext > XW'(FILL_REPORT_CAP))
                                             ? FILL_REPORT_CAP : fill_ext[6:0];
                        res_next.last        = 1'b1;
                        res_vld_next         = 1'b1;
                    end
                    else
                    begin
                        key_next      = '{cls: item.class_code, sub: item.sub_class,
                                          ifc: item.interface_code};
                        limit_next    = limit_in;
                        scan_idx_next = '0;
                        found_next    = '0;
                        pend_vld_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + FW'(1);
                    rd_vld_next   = 1'b1;
                end

                // a new hit releases the held one, which is then not the last
                if (take)
                begin
                    if (pend_vld_reg)
                    begin
                        res_next.status      = STAT_MATCH;
                        res_next.hit_bus     = pend_reg.bus;
                        res_next.hit_dev     = {3'b000, pend_reg.dev};
                        res_next.hit_func    = {5'b00000, pend_reg.func};
                        res_next.match_index = pend_ord_reg;
                        res_next.last        = 1'b0;
                        res_vld_next         = 1'b1;
                    end
                    pend_next     = rd_entry;
                    pend_ord_next = found_reg;
                    pend_vld_next = 1'b1;
                    found_next    = found_reg + 7'd1;
                end

                // nothing in flight and nothing left to read: close the query
                if (!rd_vld_reg && !issue)
                begin
                    if (pend_vld_reg)
                    begin
                        res_next.status      = STAT_MATCH;
                        res_next.hit_bus     = pend_reg.bus;
                        res_next.hit_dev     = {3'b000, pend_reg.dev};
                        res_next.hit_func    = {5'b00000, pend_reg.func};
                        res_next.match_index = pend_ord_reg;
                    end
                    else
                    begin
                        res_next.status      = STAT_NO_MATCH;
                        res_next.hit_bus     = NO_HIT;
                        res_next.hit_dev     = NO_HIT;
                        res_next.hit_func    = NO_HIT;
                        res_next.match_index = 7'd0;
                    end
                    res_next.last = 1'b1;
                    res_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        limit_reg    <= limit_next;
        pend_reg     <= pend_next;
        pend_ord_reg <= pend_ord_next;
        res_reg      <= res_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = res_vld_reg;
    assign result        = res_reg;

endmodule

// File: rtl/dcts_checker.sv
// port-level checks of the device class table search top level
// depends on dcts_pkg and the assertion macro header
`include "device_class_table_search_top_macros.svh"

module dcts_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input dcts_pkg::item_t   item,
    input logic              result_strobe,
    input dcts_pkg::result_t result
);
    import dcts_pkg::*;

    // an insert answers in the very next cycle with an insert status
    `DCTS_ASSERT_NEXT(a_insert_answer, start && !busy && (item.cmd == CMD_INSERT),
        result_strobe && result.last && (result.status == STAT_INSERTED
        || result.status == STAT_ABSENT || result.status == STAT_FULL))
    // a query holds the block busy from the next cycle
    `DCTS_ASSERT_NEXT(a_query_busy, start && !busy && (item.cmd != CMD_INSERT), busy)
    // a no-match transaction is single and carries no location
    `DCTS_ASSERT_NOW(a_no_match_form, result_strobe && (result.status == STAT_NO_MATCH),
        result.last && (result.match_index == 7'd0) && (result.hit_bus == NO_HIT))
    // a match location comes from stored 5-bit device and 3-bit function fields
    `DCTS_ASSERT_NOW(a_match_loc, result_strobe && (result.status == STAT_MATCH),
        (result.hit_dev < 8'd32) && (result.hit_func < 8'd8))

endmodule

bind device_class_table_search_top dcts_checker u_dcts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);
